// ===== hw/rtl/krt_pkg.sv =====
package krt_pkg;

  // table geometry
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int ID_W     = 31;
  localparam int YEAR_W   = 16;
  localparam int COPIES_W = 16;
  localparam int MATCH_W  = 7;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_RANGE  = 3'd4,
    CMD_MIN    = 3'd5,
    CMD_MAX    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEL_RD,
    S_DEL_WR,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [ID_W-1:0]            key_id;
    logic [ID_W-1:0]            new_id;
    logic signed [YEAR_W-1:0]   rec_year;
    logic signed [YEAR_W-1:0]   year_upper;
    logic [COPIES_W-1:0]        rec_copies;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic [ID_W-1:0]            out_id;
    logic signed [YEAR_W-1:0]   out_year;
    logic [COPIES_W-1:0]        out_copies;
    logic [MATCH_W-1:0]         match_count;
    logic                       last;
  } rsp_t;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]            id;
    logic signed [YEAR_W-1:0]   year;
    logic [COPIES_W-1:0]        copies;
  } rec_t;

  // store write and read port controls
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rec_t              data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  function automatic rsp_t mk_rsp(status_t st, rec_t r, logic [MATCH_W-1:0] cnt,
                                  logic lst);
    rsp_t o;
    o.status      = st;
    o.out_id      = r.id;
    o.out_year    = r.year;
    o.out_copies  = r.copies;
    o.match_count = cnt;
    o.last        = lst;
    return o;
  endfunction

endpackage

// ===== hw/rtl/krt_store.sv =====
module krt_store (
  input  logic             clk,
  input  krt_pkg::mem_wr_t wr,
  input  krt_pkg::mem_rd_t rd,
  output krt_pkg::rec_t    rd_data
);

  krt_pkg::rec_t mem [krt_pkg::CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== hw/rtl/keyed_record_table.sv =====
// channel   dir  handshake              payload
// --------  ---  ---------------------  -------------------------------
// request   in   req_valid / req_ready  req (krt_pkg::req_t)
// response  out  rsp_valid / rsp_ready  rsp (krt_pkg::rsp_t)
//
// insert and unknown commands need no scan; lookup, update and min/max
// scan the n stored records one per cycle through the single read port
// of the record store; delete then reads the last record and moves it
// into the freed slot. year range scans twice.
// sync reset empties the table; no clearing pass is needed.
// a busy response register stalls the range scan and the final result.
module keyed_record_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  krt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output krt_pkg::rsp_t rsp
);

  krt_pkg::state_t             state, state_next;
  logic [krt_pkg::CNT_W-1:0]   occ, occ_next;
  logic [krt_pkg::CNT_W-1:0]   iss, iss_next;
  logic [krt_pkg::ADDR_W-1:0]  chk, chk_next;
  logic [krt_pkg::ADDR_W-1:0]  hit_idx, hit_idx_next;
  logic                        rd_vld, rd_vld_next;
  logic                        pass2, pass2_next;
  logic [krt_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [krt_pkg::CNT_W-1:0]   k, k_next;
  logic [krt_pkg::COPIES_W-1:0] best, best_next;
  krt_pkg::req_t               req_q, req_q_next;
  krt_pkg::rsp_t               res, res_next;
  logic                        rsp_valid_next;
  krt_pkg::rsp_t               rsp_next;

  krt_pkg::mem_wr_t            wr;
  krt_pkg::mem_rd_t            rd;
  krt_pkg::rec_t               rd_data;

  logic                        out_free;
  logic                        out_load;
  krt_pkg::rsp_t               out_data;
  logic                        stall;
  logic                        hit;
  logic                        in_range;
  logic                        better;
  logic [krt_pkg::CNT_W-1:0]   occ_m1;
  logic [krt_pkg::CNT_W-1:0]   k_p1;
  krt_pkg::rec_t               zero_rec;
  krt_pkg::rec_t               new_rec;
  krt_pkg::rec_t               ins_rec;
  krt_pkg::rec_t               best_rec;

  krt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // shared compare unit on the record being scanned
  always_comb begin
    in_range = ($signed(rd_data.year) >= $signed(req_q.rec_year)) &&
               ($signed(rd_data.year) <= $signed(req_q.year_upper));
    if (req_q.cmd == krt_pkg::CMD_MIN) begin
      better = rd_data.copies < best;
    end else begin
      better = rd_data.copies > best;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;
  assign occ_m1   = occ - krt_pkg::CNT_W'(1);
  assign k_p1     = k + krt_pkg::CNT_W'(1);
  assign zero_rec = '0;
  assign new_rec  = '{id: req_q.new_id, year: req_q.rec_year, copies: req_q.rec_copies};
  assign ins_rec  = '{id: req.key_id, year: req.rec_year, copies: req.rec_copies};
  assign best_rec = '{id: '0, year: '0, copies: best};

  // sequencer next state and datapath control
  always_comb begin
    state_next   = state;
    occ_next     = occ;
    iss_next     = iss;
    chk_next     = chk;
    hit_idx_next = hit_idx;
    rd_vld_next  = rd_vld;
    pass2_next   = pass2;
    cnt_next     = cnt;
    k_next       = k;
    best_next    = best;
    req_q_next   = req_q;
    res_next     = res;
    wr           = '0;
    rd           = '0;
    out_load     = 1'b0;
    out_data     = res;
    req_ready    = 1'b0;
    stall        = 1'b0;
    hit          = 1'b0;

    case (state)
      krt_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_q_next  = req;
          iss_next    = '0;
          rd_vld_next = 1'b0;
          pass2_next  = 1'b0;
          cnt_next    = '0;
          k_next      = '0;
          case (req.cmd)
            krt_pkg::CMD_INSERT: begin
              if (occ == krt_pkg::CNT_W'(krt_pkg::CAPACITY)) begin
                res_next = krt_pkg::mk_rsp(krt_pkg::ST_FULL, zero_rec, '0, 1'b1);
              end else begin
                wr.en    = 1'b1;
                wr.addr  = occ[krt_pkg::ADDR_W-1:0];
                wr.data  = ins_rec;
                occ_next = occ + krt_pkg::CNT_W'(1);
                res_next = krt_pkg::mk_rsp(krt_pkg::ST_OK, ins_rec, '0, 1'b1);
              end
              state_next = krt_pkg::S_EMIT;
            end
            krt_pkg::CMD_LOOKUP, krt_pkg::CMD_UPDATE, krt_pkg::CMD_DELETE,
            krt_pkg::CMD_RANGE, krt_pkg::CMD_MIN, krt_pkg::CMD_MAX: begin
              state_next = krt_pkg::S_SCAN;
            end
            default: begin
              res_next   = krt_pkg::mk_rsp(krt_pkg::ST_OK, zero_rec, '0, 1'b1);
              state_next = krt_pkg::S_EMIT;
            end
          endcase
        end
      end

      krt_pkg::S_SCAN: begin
        // evaluate the record from the last issued read
        if (rd_vld) begin
          case (req_q.cmd)
            krt_pkg::CMD_LOOKUP, krt_pkg::CMD_UPDATE, krt_pkg::CMD_DELETE: begin
              hit = (rd_data.id == req_q.key_id);
            end
            krt_pkg::CMD_RANGE: begin
              if (!pass2) begin
                if (in_range) begin
                  cnt_next = cnt + krt_pkg::CNT_W'(1);
                end
              end else if (in_range) begin
                if (out_free) begin
                  out_load = 1'b1;
                  out_data = krt_pkg::mk_rsp(krt_pkg::ST_OK, rd_data,
                                             krt_pkg::MATCH_W'(cnt), k_p1 == cnt);
                  k_next   = k_p1;
                end else begin
                  stall = 1'b1;
                end
              end
            end
            krt_pkg::CMD_MIN, krt_pkg::CMD_MAX: begin
              if (chk == '0 || better) begin
                best_next = rd_data.copies;
              end
            end
            default: ;
          endcase
        end

        if (hit) begin
          // first match in index order ends the search
          hit_idx_next = chk;
          rd_vld_next  = 1'b0;
          case (req_q.cmd)
            krt_pkg::CMD_UPDATE: begin
              wr.en      = 1'b1;
              wr.addr    = chk;
              wr.data    = new_rec;
              res_next   = krt_pkg::mk_rsp(krt_pkg::ST_OK, new_rec, '0, 1'b1);
              state_next = krt_pkg::S_EMIT;
            end
            krt_pkg::CMD_DELETE: begin
              res_next   = krt_pkg::mk_rsp(krt_pkg::ST_OK, rd_data, '0, 1'b1);
              state_next = krt_pkg::S_DEL_RD;
            end
            default: begin
              res_next   = krt_pkg::mk_rsp(krt_pkg::ST_OK, rd_data, '0, 1'b1);
              state_next = krt_pkg::S_EMIT;
            end
          endcase
        end else if (!stall) begin
          if (iss == occ && !rd_vld) begin
            // pass over all records done
            case (req_q.cmd)
              krt_pkg::CMD_RANGE: begin
                if (pass2) begin
                  state_next = krt_pkg::S_IDLE;
                end else if (cnt == '0) begin
                  res_next   = krt_pkg::mk_rsp(krt_pkg::ST_NOT_FOUND, zero_rec, '0, 1'b1);
                  state_next = krt_pkg::S_EMIT;
                end else begin
                  pass2_next = 1'b1;
                  iss_next   = '0;
                end
              end
              krt_pkg::CMD_MIN, krt_pkg::CMD_MAX: begin
                if (occ == '0) begin
                  res_next = krt_pkg::mk_rsp(krt_pkg::ST_EMPTY, zero_rec, '0, 1'b1);
                end else begin
                  res_next = krt_pkg::mk_rsp(krt_pkg::ST_OK, best_rec, '0, 1'b1);
                end
                state_next = krt_pkg::S_EMIT;
              end
              default: begin
                res_next   = krt_pkg::mk_rsp(krt_pkg::ST_NOT_FOUND, zero_rec, '0, 1'b1);
                state_next = krt_pkg::S_EMIT;
              end
            endcase
          end else begin
            // issue the next read
            rd_vld_next = (iss != occ);
            if (iss != occ) begin
              rd.en    = 1'b1;
              rd.addr  = iss[krt_pkg::ADDR_W-1:0];
              chk_next = iss[krt_pkg::ADDR_W-1:0];
              iss_next = iss + krt_pkg::CNT_W'(1);
            end
          end
        end
      end

      krt_pkg::S_DEL_RD: begin
        // fetch the last record
        rd.en      = 1'b1;
        rd.addr    = occ_m1[krt_pkg::ADDR_W-1:0];
        state_next = krt_pkg::S_DEL_WR;
      end

      krt_pkg::S_DEL_WR: begin
        // move it into the freed slot
        wr.en      = 1'b1;
        wr.addr    = hit_idx;
        wr.data    = rd_data;
        occ_next   = occ_m1;
        state_next = krt_pkg::S_EMIT;
      end

      krt_pkg::S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data   = res;
          state_next = krt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = krt_pkg::S_IDLE;
      end
    endcase
  end

  // response register
  always_comb begin
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    if (out_load) begin
      rsp_valid_next = 1'b1;
      rsp_next       = out_data;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= krt_pkg::S_IDLE;
      occ       <= '0;
      rd_vld    <= 1'b0;
      pass2     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rd_vld    <= rd_vld_next;
      pass2     <= pass2_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    iss     <= iss_next;
    chk     <= chk_next;
    hit_idx <= hit_idx_next;
    cnt     <= cnt_next;
    k       <= k_next;
    best    <= best_next;
    req_q   <= req_q_next;
    res     <= res_next;
    rsp     <= rsp_next;
  end

  // occupancy stays within the table
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= krt_pkg::CNT_W'(krt_pkg::CAPACITY))
    else $error("occupancy above capacity");

  // an insert into a table with room grows it by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == krt_pkg::S_IDLE && req_valid && req.cmd == krt_pkg::CMD_INSERT &&
     occ != krt_pkg::CNT_W'(krt_pkg::CAPACITY))
    |=> occ == $past(occ) + krt_pkg::CNT_W'(1))
    else $error("insert did not grow occupancy");

  // a delete only moves records in a non-empty table
  a_delete_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == krt_pkg::S_DEL_WR |-> occ != '0)
    else $error("delete move on empty table");

  // range emission never passes its own count
  a_range_count: assert property (@(posedge clk) disable iff (rst)
    (state == krt_pkg::S_SCAN && pass2) |-> k <= cnt)
    else $error("range emitted more results than matches");

  // scan reads stay inside the occupied part
  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    (state == krt_pkg::S_SCAN && rd.en) |-> iss < occ)
    else $error("scan read beyond occupancy");

endmodule
